// ----- src/ses_pkg.sv -----
// ----------------------------------------------------------------------------
// Septic spline evaluator package
// Shared widths, types, register codes and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ses_pkg;

    localparam int P_COEFF_COUNT = 8;
    localparam int P_FRAC_BITS   = 16;

    localparam int P_TIME_W    = 32;
    localparam int P_ACC_W     = 48;
    localparam int P_MULB_W    = P_TIME_W + 1;
    localparam int P_PROD_W    = P_ACC_W + P_MULB_W;
    localparam int P_SUM_W     = P_ACC_W + 1;
    localparam int P_SPLIT     = 24;
    localparam int P_IDX_W     = 3;
    localparam int P_CFG_IDX_W = 2;

    typedef logic signed [P_TIME_W-1:0]                   t_time;
    typedef logic        [P_TIME_W-1:0]                   t_udur;
    typedef logic signed [P_ACC_W-1:0]                    t_acc;
    typedef logic signed [P_MULB_W-1:0]                   t_mulb;
    typedef logic signed [P_PROD_W-1:0]                   t_prod;
    typedef logic signed [P_SUM_W-1:0]                    t_sum;
    typedef logic signed [P_ACC_W-P_SPLIT+P_MULB_W-1:0]   t_phi;
    typedef logic signed [P_SPLIT+1+P_MULB_W-1:0]         t_plo;

    localparam t_time P_START_TIME_RST   = 32'sd0;
    localparam t_time P_END_TIME_RST     = 32'sd65536;
    localparam t_udur P_INV_DURATION_RST = 32'd65536;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [P_CFG_IDX_W-1:0] {
        CFG_START_TIME   = 2'd0,
        CFG_END_TIME     = 2'd1,
        CFG_INV_DURATION = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 valid;
        t_op                  op;
        logic [P_IDX_W-1:0]   idx;
        t_time                value;
        t_time                tn;
        logic                 oow;
    } t_item;

    typedef struct packed {
        t_acc pos;
        t_acc vel;
        t_acc acc;
    } t_accs;

    function automatic t_acc f_sat48(input t_prod x);
        t_acc res;
        if ((x[P_PROD_W-1:P_ACC_W-1] == '0) || (x[P_PROD_W-1:P_ACC_W-1] == '1)) begin
            res = x[P_ACC_W-1:0];
        end else if (x[P_PROD_W-1]) begin
            res = {1'b1, {(P_ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(P_ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic t_time f_sat32(input t_prod x);
        t_time res;
        if ((x[P_PROD_W-1:P_TIME_W-1] == '0) || (x[P_PROD_W-1:P_TIME_W-1] == '1)) begin
            res = x[P_TIME_W-1:0];
        end else if (x[P_PROD_W-1]) begin
            res = {1'b1, {(P_TIME_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(P_TIME_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic t_acc f_add_sat(input t_prod q, input t_acc w);
        t_acc s;
        t_sum sum;
        s   = f_sat48(q);
        sum = t_sum'(s) + t_sum'(w);
        return f_sat48(t_prod'(sum));
    endfunction

    function automatic int f_weight(input int k, input int order);
        int w;
        w = 1;
        for (int j = 0; j < order; j++) begin
            w = w * (k - j);
        end
        return w;
    endfunction

endpackage

// ----- src/ses_mulq.sv -----
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage signed multiply, split into two partial products, with the
// product shifted right by the fraction width and truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ses_mulq #(
    parameter int FRAC_BITS = ses_pkg::P_FRAC_BITS
) (
    input  logic           i_clk,
    input  ses_pkg::t_acc  i_a,
    input  ses_pkg::t_mulb i_b,
    output ses_pkg::t_prod o_q
);

    localparam ses_pkg::t_prod L_BIAS =
        (ses_pkg::t_prod'(1) <<< FRAC_BITS) - ses_pkg::t_prod'(1);

    ses_pkg::t_phi  r_p_hi;
    ses_pkg::t_plo  r_p_lo;
    logic           r_neg;
    ses_pkg::t_prod r_q;
    ses_pkg::t_prod n_sum;
    ses_pkg::t_prod n_q;

    always_ff @(posedge i_clk) begin
        r_p_hi <= $signed(i_a[ses_pkg::P_ACC_W-1:ses_pkg::P_SPLIT]) * i_b;
        r_p_lo <= $signed({1'b0, i_a[ses_pkg::P_SPLIT-1:0]}) * i_b;
        r_neg  <= i_a[ses_pkg::P_ACC_W-1] ^ i_b[ses_pkg::P_MULB_W-1];
    end

    // A negative product gets a bias so that the shift truncates toward zero.
    always_comb begin
        n_sum = (ses_pkg::t_prod'(r_p_hi) <<< ses_pkg::P_SPLIT)
              + ses_pkg::t_prod'(r_p_lo)
              + (r_neg ? L_BIAS : ses_pkg::t_prod'(0));
        n_q   = n_sum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ----- src/ses_front.sv -----
// ----------------------------------------------------------------------------
// Septic spline front end
// Clamps the sample time into the window and forms the normalized time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ses_front #(
    parameter int FRAC_BITS = ses_pkg::P_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_opcode,
    input  logic [ses_pkg::P_IDX_W-1:0]   i_coeff_index,
    input  ses_pkg::t_time                i_coeff_value,
    input  ses_pkg::t_time                i_sample_time,
    input  ses_pkg::t_time                i_start_time,
    input  ses_pkg::t_time                i_end_time,
    input  ses_pkg::t_udur                i_inv_duration,
    output ses_pkg::t_item                o_item
);

    ses_pkg::t_item r_item1;
    ses_pkg::t_item r_item2;
    ses_pkg::t_item r_item3;
    ses_pkg::t_item r_item4;
    ses_pkg::t_mulb r_d;
    ses_pkg::t_item n_item1;
    ses_pkg::t_item n_item4;
    ses_pkg::t_time n_tc;
    ses_pkg::t_mulb n_d;
    ses_pkg::t_prod w_q;

    always_comb begin
        n_item1       = '0;
        n_item1.valid = i_valid;
        n_item1.op    = ses_pkg::t_op'(i_opcode);
        n_item1.idx   = i_coeff_index;
        n_item1.value = i_coeff_value;
        n_tc          = i_sample_time;
        if (i_sample_time < i_start_time) begin
            n_tc        = i_start_time;
            n_item1.oow = 1'b1;
        end else if (i_sample_time > i_end_time) begin
            n_tc        = i_end_time;
            n_item1.oow = 1'b1;
        end
        n_d = ses_pkg::t_mulb'(n_tc) - ses_pkg::t_mulb'(i_start_time);
    end

    always_comb begin
        n_item4    = r_item3;
        n_item4.tn = ses_pkg::f_sat32(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item1.valid <= 1'b0;
            r_item2.valid <= 1'b0;
            r_item3.valid <= 1'b0;
            r_item4.valid <= 1'b0;
        end else begin
            r_item1 <= n_item1;
            r_item2 <= r_item1;
            r_item3 <= r_item2;
            r_item4 <= n_item4;
        end
        r_d <= n_d;
    end

    ses_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_tn (
        .i_clk (i_clk),
        .i_a   (ses_pkg::t_acc'(r_d)),
        .i_b   (ses_pkg::t_mulb'(i_inv_duration)),
        .o_q   (w_q)
    );

    assign o_item = r_item4;

endmodule

// ----- src/ses_step.sv -----
// ----------------------------------------------------------------------------
// Septic spline Horner step
// One Horner step for position, velocity and acceleration, holding the
// weighted coefficient of its own power.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ses_step #(
    parameter int K         = 0,
    parameter int FRAC_BITS = ses_pkg::P_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ses_pkg::t_item  i_item,
    input  ses_pkg::t_accs  i_accs,
    output ses_pkg::t_item  o_item,
    output ses_pkg::t_accs  o_accs
);

    localparam ses_pkg::t_mulb L_ONE = ses_pkg::t_mulb'(1) <<< FRAC_BITS;
    localparam int L_W1 = ses_pkg::f_weight(K, 1);
    localparam int L_W2 = ses_pkg::f_weight(K, 2);

    ses_pkg::t_item r_item_a;
    ses_pkg::t_item r_item_b;
    ses_pkg::t_item r_item_c;
    ses_pkg::t_accs r_accs_c;
    ses_pkg::t_acc  r_w0;
    ses_pkg::t_acc  r_w1;
    ses_pkg::t_acc  r_w2;
    ses_pkg::t_mulb w_tn;
    ses_pkg::t_mulb w_b1;
    ses_pkg::t_mulb w_b2;
    ses_pkg::t_prod w_q0;
    ses_pkg::t_prod w_q1;
    ses_pkg::t_prod w_q2;
    ses_pkg::t_accs n_accs;
    logic           n_load;

    // A derivative chain whose power is below its order multiplies by one and
    // adds nothing, so it carries its value through unchanged.
    assign w_tn = ses_pkg::t_mulb'(i_item.tn);
    assign w_b1 = (K >= 1) ? w_tn : L_ONE;
    assign w_b2 = (K >= 2) ? w_tn : L_ONE;

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pos (
        .i_clk (i_clk),
        .i_a   (i_accs.pos),
        .i_b   (w_tn),
        .o_q   (w_q0)
    );

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_vel (
        .i_clk (i_clk),
        .i_a   (i_accs.vel),
        .i_b   (w_b1),
        .o_q   (w_q1)
    );

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_acc (
        .i_clk (i_clk),
        .i_a   (i_accs.acc),
        .i_b   (w_b2),
        .o_q   (w_q2)
    );

    always_comb begin
        n_load     = r_item_b.valid && (r_item_b.op == ses_pkg::OP_LOAD)
                     && (int'(r_item_b.idx) == K);
        n_accs.pos = ses_pkg::f_add_sat(w_q0, r_w0);
        n_accs.vel = ses_pkg::f_add_sat(w_q1, r_w1);
        n_accs.acc = ses_pkg::f_add_sat(w_q2, r_w2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_a.valid <= 1'b0;
            r_item_b.valid <= 1'b0;
            r_item_c.valid <= 1'b0;
            r_w0           <= '0;
            r_w1           <= '0;
            r_w2           <= '0;
        end else begin
            r_item_a <= i_item;
            r_item_b <= r_item_a;
            r_item_c <= r_item_b;
            if (n_load) begin
                r_w0 <= ses_pkg::t_acc'(r_item_b.value);
                r_w1 <= ses_pkg::t_acc'(r_item_b.value) * ses_pkg::t_acc'(L_W1);
                r_w2 <= ses_pkg::t_acc'(r_item_b.value) * ses_pkg::t_acc'(L_W2);
            end
        end
        r_accs_c <= n_accs;
    end

    assign o_item = r_item_c;
    assign o_accs = r_accs_c;

endmodule

// ----- src/ses_scale.sv -----
// ----------------------------------------------------------------------------
// Septic spline derivative scaling
// Scales velocity once and acceleration twice by the reciprocal duration
// and registers the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ses_scale #(
    parameter int FRAC_BITS = ses_pkg::P_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ses_pkg::t_item  i_item,
    input  ses_pkg::t_accs  i_accs,
    input  ses_pkg::t_udur  i_inv_duration,
    output logic            o_valid,
    output ses_pkg::t_acc   o_pos,
    output ses_pkg::t_acc   o_vel,
    output ses_pkg::t_acc   o_acc,
    output logic            o_oow
);

    ses_pkg::t_item r_item1;
    ses_pkg::t_item r_item2;
    ses_pkg::t_item r_item3;
    ses_pkg::t_item r_item4;
    ses_pkg::t_item r_item5;
    ses_pkg::t_acc  r_pos1;
    ses_pkg::t_acc  r_pos2;
    ses_pkg::t_acc  r_pos3;
    ses_pkg::t_acc  r_pos4;
    ses_pkg::t_acc  r_pos5;
    ses_pkg::t_acc  r_vel3;
    ses_pkg::t_acc  r_vel4;
    ses_pkg::t_acc  r_vel5;
    ses_pkg::t_acc  r_acc3;
    logic           r_valid;
    ses_pkg::t_acc  r_pos_out;
    ses_pkg::t_acc  r_vel_out;
    ses_pkg::t_acc  r_acc_out;
    logic           r_oow;
    ses_pkg::t_mulb w_inv;
    ses_pkg::t_prod w_q_vel;
    ses_pkg::t_prod w_q_acc1;
    ses_pkg::t_prod w_q_acc2;
    logic           n_emit;

    assign w_inv = ses_pkg::t_mulb'(i_inv_duration);

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_vel (
        .i_clk (i_clk),
        .i_a   (i_accs.vel),
        .i_b   (w_inv),
        .o_q   (w_q_vel)
    );

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_acc1 (
        .i_clk (i_clk),
        .i_a   (i_accs.acc),
        .i_b   (w_inv),
        .o_q   (w_q_acc1)
    );

    ses_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_acc2 (
        .i_clk (i_clk),
        .i_a   (r_acc3),
        .i_b   (w_inv),
        .o_q   (w_q_acc2)
    );

    assign n_emit = r_item5.valid && (r_item5.op == ses_pkg::OP_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item1.valid <= 1'b0;
            r_item2.valid <= 1'b0;
            r_item3.valid <= 1'b0;
            r_item4.valid <= 1'b0;
            r_item5.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_item1 <= i_item;
            r_item2 <= r_item1;
            r_item3 <= r_item2;
            r_item4 <= r_item3;
            r_item5 <= r_item4;
            r_valid <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos1 <= i_accs.pos;
        r_pos2 <= r_pos1;
        r_pos3 <= r_pos2;
        r_pos4 <= r_pos3;
        r_pos5 <= r_pos4;
        r_vel3 <= ses_pkg::f_sat48(w_q_vel);
        r_acc3 <= ses_pkg::f_sat48(w_q_acc1);
        r_vel4 <= r_vel3;
        r_vel5 <= r_vel4;
        if (n_emit) begin
            r_pos_out <= r_pos5;
            r_vel_out <= r_vel5;
            r_acc_out <= ses_pkg::f_sat48(w_q_acc2);
            r_oow     <= r_item5.oow;
        end
    end

    assign o_valid = r_valid;
    assign o_pos   = r_pos_out;
    assign o_vel   = r_vel_out;
    assign o_acc   = r_acc_out;
    assign o_oow   = r_oow;

endmodule

// ----- src/septic_spline_eval_core.sv -----
// ----------------------------------------------------------------------------
// Septic spline evaluation core
// An evaluate beat passes through the front end, then one Horner step per
// coefficient, then the derivative scaling, before its result beat appears.
// Throughput: one beat per cycle; busy stays low. Every Horner step takes
// three stages: two for the split multiplier and one for the saturating add.
// Reset clears all valid bits and the coefficients and loads the window registers with their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module septic_spline_eval_core #(
    parameter int COEFF_COUNT = ses_pkg::P_COEFF_COUNT,
    parameter int FRAC_BITS   = ses_pkg::P_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [ses_pkg::P_IDX_W-1:0]       i_coeff_index,
    input  logic signed [ses_pkg::P_TIME_W-1:0] i_coeff_value,
    input  logic signed [ses_pkg::P_TIME_W-1:0] i_sample_time,
    input  logic                              i_cfg_we,
    input  logic [ses_pkg::P_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ses_pkg::P_TIME_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic signed [ses_pkg::P_ACC_W-1:0] o_pos_out,
    output logic signed [ses_pkg::P_ACC_W-1:0] o_vel_out,
    output logic signed [ses_pkg::P_ACC_W-1:0] o_acc_out,
    output logic                              o_out_of_window
);

    ses_pkg::t_time r_start_time;
    ses_pkg::t_time r_end_time;
    ses_pkg::t_udur r_inv_duration;
    ses_pkg::t_item w_item [COEFF_COUNT+1];
    ses_pkg::t_accs w_accs [COEFF_COUNT+1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time   <= ses_pkg::P_START_TIME_RST;
            r_end_time     <= ses_pkg::P_END_TIME_RST;
            r_inv_duration <= ses_pkg::P_INV_DURATION_RST;
        end else if (i_cfg_we) begin
            case (ses_pkg::t_cfg_idx'(i_cfg_index))
                ses_pkg::CFG_START_TIME: begin
                    r_start_time <= ses_pkg::t_time'(i_cfg_data);
                end
                ses_pkg::CFG_END_TIME: begin
                    r_end_time <= ses_pkg::t_time'(i_cfg_data);
                end
                ses_pkg::CFG_INV_DURATION: begin
                    r_inv_duration <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    ses_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start && !busy),
        .i_opcode       (i_opcode),
        .i_coeff_index  (i_coeff_index),
        .i_coeff_value  (i_coeff_value),
        .i_sample_time  (i_sample_time),
        .i_start_time   (r_start_time),
        .i_end_time     (r_end_time),
        .i_inv_duration (r_inv_duration),
        .o_item         (w_item[0])
    );

    assign w_accs[0] = '0;

    // The first step handles the highest power of the normalized time.
    for (genvar s = 0; s < COEFF_COUNT; s++) begin : g_step
        ses_step #(
            .K         (COEFF_COUNT - 1 - s),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_item[s]),
            .i_accs  (w_accs[s]),
            .o_item  (w_item[s+1]),
            .o_accs  (w_accs[s+1])
        );
    end

    ses_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_item[COEFF_COUNT]),
        .i_accs         (w_accs[COEFF_COUNT]),
        .i_inv_duration (r_inv_duration),
        .o_valid        (o_valid),
        .o_pos          (o_pos_out),
        .o_vel          (o_vel_out),
        .o_acc          (o_acc_out),
        .o_oow          (o_out_of_window)
    );

endmodule
